/* design/btah_pkg.sv */
// ----------------------------------------------------------------------------
// btah_pkg
// Shared widths, codes, types and the hex digit encoder for the number
// to ASCII text formatter.
// ----------------------------------------------------------------------------
package btah_pkg;

  localparam int VAL_W      = 32;
  localparam int NIB_W      = 4;
  localparam int MAX_DIGITS = 10;
  localparam int BCD_W      = NIB_W * MAX_DIGITS;
  localparam int CNT_W      = $clog2(VAL_W + 1);
  localparam int CHAR_W     = 7;
  localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'h37;
  localparam logic [NIB_W-1:0]  HEX_TEN      = 4'ha;

  // width codes of value_width
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_FORMAT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BYTE_ORDER  = 2'd1;

  localparam logic FMT_HEX      = 1'b0;
  localparam logic FMT_DEC      = 1'b1;
  localparam logic ORDER_BIG    = 1'b0;
  localparam logic ORDER_LITTLE = 1'b1;

  typedef struct packed {
    logic             start;
    logic             shift;
    logic [CNT_W-1:0] nbits;
  } dab_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] base;
    base = (nib >= HEX_TEN) ? ASCII_LETTER : ASCII_ZERO;
    return base + CHAR_W'(nib);
  endfunction

endpackage

/* design/btah_dabble.sv */
// ----------------------------------------------------------------------------
// btah_dabble
// Bit-serial binary to BCD converter (shift and add three), one input bit
// per cycle; the BCD register then shifts out one digit per request.
// ----------------------------------------------------------------------------
module btah_dabble (
  input  logic                       clk,
  input  logic                       rst,
  input  btah_pkg::dab_ctl_t         ctl,
  input  logic [btah_pkg::VAL_W-1:0] value,
  output btah_pkg::dab_stat_t        stat,
  output logic [btah_pkg::NIB_W-1:0] digit
);
  import btah_pkg::*;

  logic [VAL_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // digits of five or more get three added before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[NIB_W*i +: NIB_W] >= NIB_W'(5)) begin
        bcd_adj[NIB_W*i +: NIB_W] = bcd[NIB_W*i +: NIB_W] + NIB_W'(3);
      end else begin
        bcd_adj[NIB_W*i +: NIB_W] = bcd[NIB_W*i +: NIB_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VAL_W-1]};
      bin <= {bin[VAL_W-2:0], 1'b0};
    end else if (ctl.shift) begin
      bcd <= {bcd[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign digit     = bcd[BCD_W-1 -: NIB_W];

endmodule

/* design/binary_to_ascii_hex_decimal.sv */
// ----------------------------------------------------------------------------
// binary_to_ascii_hex_decimal
// Formats an 8, 16 or 32-bit unsigned value as ASCII hex or decimal text,
// one character per output transaction, last character marked.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid in_ready value value_w. | input
//   out     | out_valid out_ready character    | output
//           | last_char                        |
//   cfg     | cfg_valid cfg_ready cfg_index    | input
//           | cfg_data                         |
//
// Hex: the value is accepted, then one character per cycle while the output
// is free (2, 4 or 8 characters). Decimal: the value is accepted and converted
// in the bit-serial BCD converter, leading zero digits are skipped (up to 9),
// then one digit a cycle while the output is free; in_ready returns in idle.
// Output stalls hold the character register and pause emission.
// Reset clears both registers to hex, most significant byte first.
// ----------------------------------------------------------------------------
module binary_to_ascii_hex_decimal (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [btah_pkg::VAL_W-1:0]      value,
  input  logic [1:0]                      value_width,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btah_pkg::CHAR_W-1:0]     character,
  output logic                            last_char,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btah_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic                            cfg_data
);
  import btah_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEX  = 3'd1;
  localparam logic [2:0] S_CONV = 3'd2;
  localparam logic [2:0] S_SKIP = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic              text_format;
  logic              byte_order;
  logic [VAL_W-1:0]  sr;
  logic [LEFT_W-1:0] nleft;
  logic              half;

  logic              in_fire;
  logic              out_free;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic [VAL_W-1:0]  v_masked;
  logic [VAL_W-1:0]  v_aligned;
  logic [CNT_W-1:0]  nbits;
  logic [LEFT_W-1:0] nchars;
  logic [NIB_W-1:0]  hex_nib;
  logic [NIB_W-1:0]  digit;
  dab_ctl_t          dab_ctl;
  dab_stat_t         dab_stat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    case (value_width)
      WIDTH_8: begin
        v_masked  = {{(VAL_W-8){1'b0}}, value[7:0]};
        v_aligned = {value[7:0], {(VAL_W-8){1'b0}}};
        nbits     = CNT_W'(8);
        nchars    = LEFT_W'(2);
      end
      WIDTH_16: begin
        v_masked  = {{(VAL_W-16){1'b0}}, value[15:0]};
        v_aligned = {value[15:0], {(VAL_W-16){1'b0}}};
        nbits     = CNT_W'(16);
        nchars    = LEFT_W'(4);
      end
      default: begin
        v_masked  = value;
        v_aligned = value;
        nbits     = CNT_W'(VAL_W);
        nchars    = LEFT_W'(8);
      end
    endcase
  end

  // little order walks bytes from the bottom, high nibble of each first
  always_comb begin
    if (byte_order == ORDER_LITTLE) begin
      hex_nib = half ? sr[NIB_W-1:0] : sr[2*NIB_W-1:NIB_W];
    end else begin
      hex_nib = sr[VAL_W-1 -: NIB_W];
    end
  end

  always_comb begin
    state_next    = state;
    emit          = 1'b0;
    emit_char     = hex_char(hex_nib);
    emit_last     = (nleft == LEFT_W'(1));
    dab_ctl.start = 1'b0;
    dab_ctl.shift = 1'b0;
    dab_ctl.nbits = nbits;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (text_format == FMT_DEC) begin
            dab_ctl.start = 1'b1;
            state_next    = S_CONV;
          end else begin
            state_next = S_HEX;
          end
        end
      end
      S_HEX: begin
        if (out_free) begin
          emit = 1'b1;
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CONV: begin
        if (dab_stat.done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (digit == '0 && nleft != LEFT_W'(1)) begin
          dab_ctl.shift = 1'b1;
        end else begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        emit_char = ASCII_ZERO + CHAR_W'(digit);
        if (out_free) begin
          emit          = 1'b1;
          dab_ctl.shift = 1'b1;
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      text_format <= FMT_HEX;
      byte_order  <= ORDER_BIG;
      out_valid   <= 1'b0;
      nleft       <= '0;
      half        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEXT_FORMAT: text_format <= cfg_data;
          REG_BYTE_ORDER:  byte_order  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        nleft <= (text_format == FMT_DEC) ? LEFT_W'(MAX_DIGITS) : nchars;
        half  <= 1'b0;
      end else if (emit || dab_ctl.shift) begin
        nleft <= nleft - LEFT_W'(1);
        half  <= !half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character <= emit_char;
      last_char <= emit_last;
    end
    if (in_fire) begin
      sr <= (byte_order == ORDER_LITTLE) ? v_masked : v_aligned;
    end else if (emit && state == S_HEX) begin
      if (byte_order == ORDER_LITTLE) begin
        if (half) begin
          sr <= {8'b0, sr[VAL_W-1:8]};
        end
      end else begin
        sr <= {sr[VAL_W-NIB_W-1:0], {NIB_W{1'b0}}};
      end
    end
  end

  btah_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .ctl   (dab_ctl),
    .value (v_aligned),
    .stat  (dab_stat),
    .digit (digit)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the number to ASCII text formatter. A directed
// table covers value extremes, all width codes, truncation of narrow values
// and both formats and byte orders. Random values then run under every
// register setting. Each character is checked against typed text or the model.
// ----------------------------------------------------------------------------
module testbench;
  import btah_pkg::*;

  localparam logic [1:0] WIDTH_32    = 2'd2;
  localparam logic [1:0] WIDTH_WIDE3 = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [VAL_W-1:0] DEC_BASE = 32'd10;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 51;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_N        = 24;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // len of zero means the row is checked against the formatter model
  typedef struct {
    logic             fmt;
    logic             order;
    logic [VAL_W-1:0] val;
    logic [1:0]       wcode;
    int               len;
    logic [79:0]      txt;
  } dir_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PATTERN
  } ready_mode_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     value       = '0;
  logic [1:0]           value_width = WIDTH_8;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [CHAR_W-1:0]    character;
  logic                 last_char;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index   = REG_TEXT_FORMAT;
  logic                 cfg_data    = 1'b0;

  // typed text of a directed row, travels with the input transaction
  int          typed_len = 0;
  logic [79:0] typed_txt = '0;

  text_char_t  pending_chars[$];
  logic        model_fmt   = FMT_HEX;
  logic        model_order = ORDER_BIG;
  logic        drv_fmt     = FMT_HEX;
  logic        drv_order   = ORDER_BIG;
  int          burst_left  = 0;
  int          fail_n      = 0;
  int          report_n    = 0;
  int          cycle_n     = 0;

  ready_mode_t ready_mode  = READY_ALWAYS;
  int          mode_left   = 0;
  logic [4:0]  ready_pat   = 5'b10110;

  dir_row_t dir_rows [DIR_N] = '{
    // reset defaults: hex, most significant byte first
    '{FMT_HEX, ORDER_BIG,    32'h0000_0000, WIDTH_8,     2, "00"},
    '{FMT_HEX, ORDER_BIG,    32'h0000_00FF, WIDTH_8,     2, "FF"},
    '{FMT_HEX, ORDER_BIG,    32'hFFFF_FF5A, WIDTH_8,     2, "5A"},
    '{FMT_HEX, ORDER_BIG,    32'h0000_FFFF, WIDTH_16,    4, "FFFF"},
    '{FMT_HEX, ORDER_BIG,    32'hDEAD_12AB, WIDTH_16,    4, "12AB"},
    '{FMT_HEX, ORDER_BIG,    32'hFFFF_FFFF, WIDTH_32,    8, "FFFFFFFF"},
    '{FMT_HEX, ORDER_BIG,    32'h0000_0000, WIDTH_32,    8, "00000000"},
    '{FMT_HEX, ORDER_BIG,    32'h0123_ABCD, WIDTH_32,    8, "0123ABCD"},
    '{FMT_HEX, ORDER_BIG,    32'h89AB_CDEF, WIDTH_WIDE3, 8, "89ABCDEF"},
    '{FMT_HEX, ORDER_LITTLE, 32'h0000_00C3, WIDTH_8,     2, "C3"},
    '{FMT_HEX, ORDER_LITTLE, 32'hDEAD_12AB, WIDTH_16,    4, "AB12"},
    '{FMT_HEX, ORDER_LITTLE, 32'h0123_ABCD, WIDTH_32,    8, "CDAB2301"},
    '{FMT_HEX, ORDER_LITTLE, 32'h0000_009F, WIDTH_WIDE3, 8, "9F000000"},
    '{FMT_HEX, ORDER_LITTLE, 32'h5EC7_91A4, WIDTH_32,    0, "0"},
    '{FMT_DEC, ORDER_LITTLE, 32'h0000_0000, WIDTH_8,     1, "0"},
    '{FMT_DEC, ORDER_LITTLE, 32'h0000_00FF, WIDTH_8,     3, "255"},
    '{FMT_DEC, ORDER_LITTLE, 32'h0000_FFFF, WIDTH_16,    5, "65535"},
    '{FMT_DEC, ORDER_LITTLE, 32'hFFFF_FFFF, WIDTH_32,   10, "4294967295"},
    '{FMT_DEC, ORDER_LITTLE, 32'hFFFF_FF0A, WIDTH_8,     2, "10"},
    '{FMT_DEC, ORDER_LITTLE, 32'h3B9A_CA00, WIDTH_WIDE3,10, "1000000000"},
    '{FMT_DEC, ORDER_LITTLE, 32'h0000_0009, WIDTH_32,    1, "9"},
    '{FMT_DEC, ORDER_BIG,    32'h0001_0000, WIDTH_16,    1, "0"},
    '{FMT_DEC, ORDER_BIG,    32'h075B_CD15, WIDTH_32,    9, "123456789"},
    '{FMT_DEC, ORDER_BIG,    32'h77AA_9C40, WIDTH_16,    0, "0"}
  };

  binary_to_ascii_hex_decimal dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] nibble_char(logic [NIB_W-1:0] nib);
    if (nib >= HEX_TEN) return ASCII_LETTER + CHAR_W'(nib);
    return ASCII_ZERO + CHAR_W'(nib);
  endfunction

  // appends one expected character at the tail of the queue
  function automatic void queue_char(logic [CHAR_W-1:0] ch, logic last);
    pending_chars.insert(pending_chars.size(), '{ch, last});
  endfunction

  // queues the characters the formatter should emit for one value
  function automatic void predict_text(logic [VAL_W-1:0] v_in, logic [1:0] wcode);
    logic [VAL_W-1:0] v;
    logic [7:0]       byt;
    logic [3:0]       digs [MAX_DIGITS];
    int               nbytes;
    int               idx;
    int               n;
    case (wcode)
      WIDTH_8: begin
        nbytes = 1;
        v = {24'h0, v_in[7:0]};
      end
      WIDTH_16: begin
        nbytes = 2;
        v = {16'h0, v_in[15:0]};
      end
      default: begin
        nbytes = 4;
        v = v_in;
      end
    endcase
    if (model_fmt == FMT_HEX) begin
      for (int b = 0; b < nbytes; b++) begin
        idx = (model_order == ORDER_BIG) ? nbytes - 1 - b : b;
        byt = v[8*idx +: 8];
        queue_char(nibble_char(byt[7:4]), 1'b0);
        queue_char(nibble_char(byt[3:0]), b == nbytes - 1);
      end
    end else begin
      n = 0;
      do begin
        digs[n] = 4'(v % DEC_BASE);
        v = v / DEC_BASE;
        n++;
      end while (v != 0 && n < MAX_DIGITS);
      for (int d = n - 1; d >= 0; d--) begin
        queue_char(ASCII_ZERO + CHAR_W'(digs[d]), d == 0);
      end
    end
  endfunction

  // register mirror, expected text and character check
  always @(posedge clk) begin : monitor
    text_char_t got;
    text_char_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEXT_FORMAT) model_fmt = cfg_data;
        else if (cfg_index == REG_BYTE_ORDER) model_order = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (typed_len != 0) begin
          for (int k = 0; k < typed_len; k++) begin
            queue_char(typed_txt[8*(typed_len-1-k) +: CHAR_W], k == typed_len - 1);
          end
        end else begin
          predict_text(value, value_width);
        end
      end
      if (out_valid && out_ready) begin
        got = '{character, last_char};
        if (pending_chars.size() == 0) begin
          fail_n++;
          if (report_n < MAX_REPORTS)
            $display("unexpected character %h last %b", got.ch, got.last);
          report_n++;
        end else begin
          want = pending_chars.pop_front();
          if (got.ch !== want.ch || got.last !== want.last) begin
            fail_n++;
            if (report_n < MAX_REPORTS)
              $display("mismatch: character %h last %b, expected character %h last %b",
                       got.ch, got.last, want.ch, want.last);
            report_n++;
          end
        end
      end
    end
  end

  // receiver stalls, a new ready mode is drawn whenever the mode counter runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(24, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    ready_pat <= {ready_pat[3:0], ready_pat[4]};
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= ready_pat[0];
    endcase
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [VAL_W-1:0] v, input logic [1:0] w,
                           input int len, input logic [79:0] txt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    value       <= v;
    value_width <= w;
    typed_len   <= len;
    typed_txt   <= txt;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // spare indexes must leave both registers alone
  task automatic set_config(input logic fmt, input logic order);
    wait_idle();
    cfg_write(REG_TEXT_FORMAT, fmt);
    cfg_write(REG_BYTE_ORDER, order);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 1'($urandom_range(0, 1)));
    cfg_valid <= 1'b0;
    drv_fmt   = fmt;
    drv_order = order;
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] pow;
    logic [1:0]       w;
    logic             fmt_sel;
    logic             order_sel;
    int               wsel;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].fmt !== drv_fmt || dir_rows[r].order !== drv_order)
        set_config(dir_rows[r].fmt, dir_rows[r].order);
      send_item(dir_rows[r].val, dir_rows[r].wcode, dir_rows[r].len, dir_rows[r].txt);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      fmt_sel   = (p < 4) ? 1'(p >> 1) : 1'($urandom_range(0, 1));
      order_sel = (p < 4) ? 1'(p) : 1'($urandom_range(0, 1));
      set_config(fmt_sel, order_sel);
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 5))
          1: v = $urandom_range(0, 20);
          2: v = 32'hFFFF_FFFF >> $urandom_range(0, 31);
          3: begin
            // around powers of ten, where the digit count changes
            pow = 32'd1;
            repeat ($urandom_range(0, 9)) pow = pow * DEC_BASE;
            v = pow - $urandom_range(0, 1);
          end
          5: v = {16'($urandom()), 8'h00, 8'($urandom())};
          default: v = $urandom();
        endcase
        wsel = $urandom_range(0, 9);
        if (wsel < 3) w = WIDTH_8;
        else if (wsel < 6) w = WIDTH_16;
        else if (wsel < 9) w = WIDTH_32;
        else w = WIDTH_WIDE3;
        send_item(v, w, 0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_n == 0 && pending_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
